FILE: hw/rtl/plst_pkg.sv
// plst_pkg: shared types and codes for the positional list store.
// Holds operation codes, status codes, field widths and the per-cell control struct.
// No dependencies.
package plst_pkg;

    localparam int DATA_W  = 32;
    localparam int MODE_W  = 3;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    localparam int DEPTH_DEFAULT = 64;

    // Operation codes carried on the mode field
    localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RETRIEVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REPLACE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;

    // What one cell does in the current cycle; at most one member is set
    typedef struct packed {
        logic load;       // take the broadcast value
        logic shift_up;   // take the entry of the cell below
        logic shift_down; // take the entry of the cell above
    } t_cell_ctl;

endpackage

FILE: hw/rtl/plst_cell.sv
// plst_cell: one entry of the list chain.
// Loads the broadcast value or takes a neighbor's entry; depends on plst_pkg.
module plst_cell (
    input  logic                        i_clk,
    input  plst_pkg::t_cell_ctl         i_ctl,
    input  logic [plst_pkg::DATA_W-1:0] i_value,
    input  logic [plst_pkg::DATA_W-1:0] i_lower,
    input  logic [plst_pkg::DATA_W-1:0] i_upper,
    output logic [plst_pkg::DATA_W-1:0] o_data
);
    import plst_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_value;
        end else if (i_ctl.shift_up) begin
            n_data = i_lower;
        end else if (i_ctl.shift_down) begin
            n_data = i_upper;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: hw/rtl/positional_list_store.sv
// positional_list_store: ordered list of up to DEPTH signed 32-bit entries.
// Top level; builds the cell chain from plst_cell and uses plst_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one operation per transfer:
//   i_mode selects insert, remove, retrieve, replace or clear, i_position is the
//   zero-based target and i_value the data for insert and replace.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result per
//   operation: status, the removed or retrieved value, the entry count after
//   the operation (low 7 bits) and an empty flag.
//   Latency: the result is valid in the cycle after the input transfer.
//   Throughput: one operation per cycle while i_out_ready is high. Every cell
//   of the chain updates in the cycle of the transfer, so an insert or remove
//   shifts the whole list at once; the limit is the one-result output register.
//   Stall: while a result waits and i_out_ready is low, o_in_ready is low;
//   when the receiver takes the result the next operation is taken in the
//   same cycle.
//   Reset: i_rst_n low (synchronous) empties the list and drops o_out_valid.
//   Entry contents are not cleared; positions at or above the count are never
//   read.
module positional_list_store #(
    parameter int DEPTH = plst_pkg::DEPTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // operation channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [plst_pkg::MODE_W-1:0]  i_mode,
    input  logic [plst_pkg::POS_W-1:0]   i_position,
    input  logic signed [plst_pkg::DATA_W-1:0] i_value,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [plst_pkg::STAT_W-1:0]  o_status,
    output logic signed [plst_pkg::DATA_W-1:0] o_read_value,
    output logic [plst_pkg::COUNT_W-1:0] o_entry_count,
    output logic                         o_is_empty
);
    import plst_pkg::*;

    // count width, index width, and a compare width wide enough for both
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    // list length
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;

    // result register
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] n_rdata;
    logic [LEN_W-1:0]  r_count;

    logic              w_xfer;
    logic [CMP_W-1:0]  w_pos;
    logic [CMP_W-1:0]  w_len;
    logic              w_ins_ok;
    logic              w_rem_ok;
    logic              w_rep_ok;
    logic              w_acc_ok;   // position addresses a live entry
    logic [DATA_W-1:0] w_sel_data;

    logic [DATA_W-1:0] w_cell_data [DEPTH];
    t_cell_ctl         w_cell_ctl  [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_xfer     = i_in_valid && o_in_ready;

    assign w_pos = CMP_W'(i_position);
    assign w_len = CMP_W'(r_len);

    assign w_acc_ok = (w_pos < w_len);
    assign w_ins_ok = w_xfer && (i_mode == MODE_INSERT) && (w_pos <= w_len) && (w_len < DEPTH_C);
    assign w_rem_ok = w_xfer && (i_mode == MODE_REMOVE) && w_acc_ok;
    assign w_rep_ok = w_xfer && (i_mode == MODE_REPLACE) && w_acc_ok;

    // the entry at the target position; only used when it is live
    assign w_sel_data = w_cell_data[w_pos[IDX_W-1:0]];

    // Cell chain: cell k takes the cell below on insert above the target, the
    // cell above on remove at or above it, the new value at it on insert/replace.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam logic [CMP_W-1:0] K_C = CMP_W'(k);

        assign w_cell_ctl[k].load       = (w_ins_ok || w_rep_ok) && (w_pos == K_C);
        assign w_cell_ctl[k].shift_up   = w_ins_ok && (K_C > w_pos);
        assign w_cell_ctl[k].shift_down = w_rem_ok && (K_C >= w_pos);

        plst_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_cell_ctl[k]),
            .i_value (i_value),
            .i_lower (w_cell_data[(k == 0) ? 0 : k - 1]),
            .i_upper (w_cell_data[(k == DEPTH - 1) ? k : k + 1]),
            .o_data  (w_cell_data[k])
        );
    end

    // status, read data and new length
    always_comb begin
        n_status = ST_OK;
        n_rdata  = '0;
        n_len    = r_len;
        case (i_mode)
            MODE_INSERT: begin
                if (w_pos > w_len) begin
                    n_status = ST_UNDER;
                end else if (w_len >= DEPTH_C) begin
                    n_status = ST_OVER;
                end else begin
                    n_len = r_len + 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (!w_acc_ok) begin
                    n_status = ST_UNDER;
                end else begin
                    n_rdata = w_sel_data;
                    n_len   = r_len - 1'b1;
                end
            end
            MODE_RETRIEVE: begin
                if (!w_acc_ok) begin
                    n_status = ST_UNDER;
                end else begin
                    n_rdata = w_sel_data;
                end
            end
            MODE_REPLACE: begin
                if (!w_acc_ok) begin
                    n_status = ST_UNDER;
                end
            end
            MODE_CLEAR: begin
                n_len = '0;
            end
            default: begin
                // unused modes: no change, success
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_xfer) begin
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_status <= n_status;
            r_rdata  <= n_rdata;
            r_count  <= n_len;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_rdata;
    assign o_entry_count = COUNT_W'(r_count);
    assign o_is_empty    = (r_count == '0);

`ifndef SYNTH
    // every transfer in produces a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer |=> o_out_valid)
        else $error("result missing after input transfer");

    // the list never grows past its capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_len) <= DEPTH_C)
        else $error("list length above capacity");

    // overflow is only reported with a full list
    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OVER)) |-> (CMP_W'(r_count) == DEPTH_C))
        else $error("overflow status with list not full");

    // a failed operation returns no data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_read_value == '0))
        else $error("nonzero read data on failed operation");
`endif

endmodule
